### rtl/ed2x_pkg.sv
`default_nettype none
package ed2x_pkg;

	localparam int MAX_WIDTH   = 128;
	localparam int MAX_HEIGHT  = 128;
	localparam int NUM_SLOTS   = 4;
	localparam int NUM_BANKS   = 4;
	localparam int BANK_DEPTH  = MAX_WIDTH / NUM_BANKS;
	localparam int PIX_W       = 8;
	localparam int POS_W       = 7;
	localparam int DIM_W       = 8;
	localparam int SLOT_W      = 2;
	localparam int BANK_W      = 2;
	localparam int ADDR_W      = $clog2(BANK_DEPTH);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	localparam logic [DIM_W-1:0] DIM_MIN   = 8'd4;
	localparam logic [DIM_W-1:0] WIDTH_MAX = DIM_W'(MAX_WIDTH);
	localparam logic [DIM_W-1:0] HEIGHT_MAX = DIM_W'(MAX_HEIGHT);

	localparam logic [1:0] REG_ACTIVE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_ACTIVE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_TIE_THRESHOLD = 2'd2;

	typedef struct packed {
		logic [DIM_W-1:0] w;
		logic [DIM_W-1:0] h;
		logic [PIX_W-1:0] thresh;
	} frame_cfg_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] slot;
		logic [POS_W-1:0]  col;
		logic [PIX_W-1:0]  data;
	} line_wr_t;

	typedef struct packed {
		logic [POS_W-1:0]  x;
		logic [POS_W-1:0]  y;
		logic [SLOT_W-1:0] base;
		logic              last;
		logic              done;
	} blk_req_t;

	// Catmull-Rom half pixel, limited to the span of the two middle taps
	function automatic logic [PIX_W-1:0] half_tap(input logic [PIX_W-1:0] p0,
			input logic [PIX_W-1:0] p1, input logic [PIX_W-1:0] p2,
			input logic [PIX_W-1:0] p3);
		logic [13:0] mid;
		logic [13:0] pos;
		logic [13:0] neg;
		logic signed [13:0] v;
		logic signed [9:0] q;
		logic [PIX_W-1:0] lo;
		logic [PIX_W-1:0] hi;
		mid = {6'd0, p1} + {6'd0, p2};
		pos = (mid << 3) + mid + 14'd8;
		neg = {6'd0, p0} + {6'd0, p3};
		v = $signed(pos - neg);
		q = 10'(v >>> 4);
		lo = (p1 < p2) ? p1 : p2;
		hi = (p1 < p2) ? p2 : p1;
		if (q < $signed({2'b00, lo}))
			half_tap = lo;
		else if (q > $signed({2'b00, hi}))
			half_tap = hi;
		else
			half_tap = q[PIX_W-1:0];
	endfunction

	function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
			input logic [PIX_W-1:0] b);
		abs_diff = (a > b) ? a - b : b - a;
	endfunction

endpackage
`default_nettype wire

### rtl/ed2x_queue.sv
`default_nettype none
module ed2x_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  ed2x_pkg::blk_req_t     din,
	output logic                   full,
	input  wire logic              pop,
	output ed2x_pkg::blk_req_t     dout,
	output logic                   empty
);
	import ed2x_pkg::*;

	blk_req_t            slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign dout  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/ed2x_front.sv
`default_nettype none
module ed2x_front (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  ed2x_pkg::frame_cfg_t          cfg,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [7:0]               pixel,
	input  wire logic                     start_of_frame,
	output ed2x_pkg::line_wr_t            line_wr,
	output logic                          req_push,
	output ed2x_pkg::blk_req_t            req,
	input  wire logic                     req_full,
	input  wire logic                     req_empty
);
	import ed2x_pkg::*;

	logic [POS_W-1:0]  col_q;
	logic [POS_W-1:0]  row_q;
	logic [SLOT_W-1:0] slot_q;

	logic              job_valid_q;
	logic [POS_W-1:0]  job_c_q;
	logic [POS_W-1:0]  job_r_q;
	logic [SLOT_W-1:0] job_slot_q;
	logic              job_mcol_q;
	logic              job_mrow_q;
	logic [1:0]        job_i_q;
	logic [1:0]        job_j_q;

	logic              wrap_col;
	logic [POS_W-1:0]  c_arr;
	logic [DIM_W-1:0]  r_pre;
	logic [POS_W-1:0]  r_arr;
	logic [DIM_W-1:0]  c_inc;
	logic [DIM_W-1:0]  r_inc;
	logic [POS_W-1:0]  col_n;
	logic [POS_W-1:0]  row_n;
	logic              row_start;
	logic [SLOT_W-1:0] slot_n;
	logic              accept;
	logic              emit;
	logic              last_i;
	logic              last_j;
	logic              emit_last;
	logic              job_free;
	logic [DIM_W-1:0]  bx;
	logic [DIM_W-1:0]  by;

	// position of the arriving pixel, wrapped against the current frame size
	always_comb begin
		wrap_col = !start_of_frame && ({1'b0, col_q} >= cfg.w);
		c_arr = (start_of_frame || wrap_col) ? '0 : col_q;
		r_pre = start_of_frame ? '0 : {1'b0, row_q} + DIM_W'(wrap_col);
		r_arr = (r_pre >= cfg.h) ? '0 : r_pre[POS_W-1:0];
		row_start = (c_arr == '0);
		slot_n = row_start ? slot_q + 1'b1 : slot_q;
		c_inc = {1'b0, c_arr} + 1'b1;
		if (c_inc >= cfg.w) begin
			col_n = '0;
			r_inc = {1'b0, r_arr} + 1'b1;
		end else begin
			col_n = c_inc[POS_W-1:0];
			r_inc = {1'b0, r_arr};
		end
		row_n = (r_inc >= cfg.h) ? '0 : r_inc[POS_W-1:0];
	end

	assign emit      = job_valid_q && !req_full;
	assign last_j    = !job_mcol_q || (job_j_q == 2'd2);
	assign last_i    = !job_mrow_q || (job_i_q == 2'd2);
	assign emit_last = emit && last_i && last_j;
	assign job_free  = !job_valid_q || emit_last;

	// a new row overwrites the oldest slot: drain pending blocks first
	assign in_stall = !job_free || (row_start && (job_valid_q || !req_empty));
	assign accept   = in_valid && !in_stall;

	assign line_wr.en   = accept;
	assign line_wr.slot = slot_n;
	assign line_wr.col  = c_arr;
	assign line_wr.data = pixel;

	always_comb begin
		case (job_j_q)
			2'd0:    bx = {1'b0, job_c_q} - 8'd2;
			2'd1:    bx = cfg.w - 8'd2;
			default: bx = cfg.w - 8'd1;
		endcase
		case (job_i_q)
			2'd0:    by = {1'b0, job_r_q} - 8'd2;
			2'd1:    by = {1'b0, job_r_q} - 8'd1;
			default: by = {1'b0, job_r_q};
		endcase
		req.x    = bx[POS_W-1:0];
		req.y    = by[POS_W-1:0];
		req.base = job_slot_q + SLOT_W'(job_i_q) + 1'b1;
		req.last = last_i && last_j;
		req.done = (bx == cfg.w - 8'd1) && (by == cfg.h - 8'd1);
	end

	assign req_push = emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			slot_q      <= '0;
			job_valid_q <= 1'b0;
			job_i_q     <= '0;
			job_j_q     <= '0;
		end else begin
			if (accept) begin
				col_q  <= col_n;
				row_q  <= row_n;
				slot_q <= slot_n;
			end
			if (accept && r_arr >= POS_W'(2) && c_arr >= POS_W'(2)) begin
				job_valid_q <= 1'b1;
				job_i_q     <= '0;
				job_j_q     <= '0;
			end else if (emit_last) begin
				job_valid_q <= 1'b0;
			end else if (emit) begin
				if (last_j) begin
					job_j_q <= '0;
					job_i_q <= job_i_q + 1'b1;
				end else begin
					job_j_q <= job_j_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_c_q    <= c_arr;
			job_r_q    <= r_arr;
			job_slot_q <= slot_n;
			job_mcol_q <= ({1'b0, c_arr} == cfg.w - 8'd1);
			job_mrow_q <= ({1'b0, r_arr} == cfg.h - 8'd1);
		end
	end

endmodule
`default_nettype wire

### rtl/ed2x_back.sv
`default_nettype none
module ed2x_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  ed2x_pkg::frame_cfg_t       cfg,
	input  ed2x_pkg::line_wr_t         line_wr,
	input  wire logic                  req_valid,
	input  ed2x_pkg::blk_req_t         req,
	output logic                       req_pop,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [7:0]                 top_left,
	output logic [7:0]                 top_right,
	output logic [7:0]                 bottom_left,
	output logic [7:0]                 bottom_right,
	output logic [6:0]                 block_column,
	output logic [6:0]                 block_row,
	output logic                       last_of_run,
	output logic                       frame_done
);
	import ed2x_pkg::*;

	logic [PIX_W-1:0] line_mem [NUM_SLOTS][NUM_BANKS][BANK_DEPTH];

	logic             adv;
	logic             valid_s1;
	blk_req_t         req_s1;
	logic [PIX_W-1:0] rd_s1 [NUM_SLOTS][NUM_BANKS];
	logic             valid_s2;
	blk_req_t         req_s2;
	logic [PIX_W-1:0] win_s2 [4][4];
	logic             out_valid_q;

	logic [DIM_W-1:0]  xm1;
	logic [ADDR_W-1:0] rd_addr [NUM_BANKS];
	logic [PIX_W-1:0]  win [4][4];

	logic [PIX_W-1:0] pc;
	logic [PIX_W-1:0] ne;
	logic [PIX_W-1:0] sw;
	logic [PIX_W-1:0] se;
	logic [PIX_W-1:0] g1;
	logic [PIX_W-1:0] g2;
	logic [PIX_W:0]   g1t;
	logic [PIX_W:0]   g2t;
	logic [PIX_W+1:0] sum4;
	logic [PIX_W-1:0] centre;

	assign adv     = !out_valid_q || !out_stall;
	assign req_pop = req_valid && adv;

	// each bank holds one column of x-1..x+2; off-frame columns read junk and are replaced later
	always_comb begin
		logic [BANK_W-1:0] off;
		logic [DIM_W-1:0]  col;
		xm1 = {1'b0, req.x} - 8'd1;
		for (int b = 0; b < NUM_BANKS; b++) begin
			off = BANK_W'(b) - xm1[BANK_W-1:0];
			col = xm1 + {{(DIM_W-BANK_W){1'b0}}, off};
			rd_addr[b] = col[ADDR_W+BANK_W-1:BANK_W];
		end
	end

	always_ff @(posedge clk) begin
		if (line_wr.en)
			line_mem[line_wr.slot][line_wr.col[BANK_W-1:0]][line_wr.col[POS_W-1:BANK_W]]
				<= line_wr.data;
		if (req_pop) begin
			req_s1 <= req;
			for (int s = 0; s < NUM_SLOTS; s++)
				for (int b = 0; b < NUM_BANKS; b++)
					rd_s1[s][b] <= line_mem[s][b][rd_addr[b]];
		end
	end

	// arrange the 4x4 window and clamp it at the frame edges
	always_comb begin
		logic [SLOT_W-1:0] sl;
		logic [BANK_W-1:0] bk;
		logic [DIM_W-1:0]  xs;
		logic [DIM_W-1:0]  ys;
		xs = {1'b0, req_s1.x};
		ys = {1'b0, req_s1.y};
		for (int k = 0; k < 4; k++) begin
			sl = req_s1.base + SLOT_W'(k);
			for (int m = 0; m < 4; m++) begin
				bk = BANK_W'(req_s1.x) - 1'b1 + BANK_W'(m);
				win[k][m] = rd_s1[sl][bk];
			end
		end
		for (int m = 0; m < 4; m++) begin
			if (ys == '0)
				win[0][m] = win[1][m];
			if (ys == cfg.h - 8'd1) begin
				win[2][m] = win[1][m];
				win[3][m] = win[1][m];
			end else if (ys == cfg.h - 8'd2) begin
				win[3][m] = win[2][m];
			end
		end
		for (int k = 0; k < 4; k++) begin
			if (xs == '0)
				win[k][0] = win[k][1];
			if (xs == cfg.w - 8'd1) begin
				win[k][2] = win[k][1];
				win[k][3] = win[k][1];
			end else if (xs == cfg.w - 8'd2) begin
				win[k][3] = win[k][2];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			req_s2 <= req_s1;
			for (int k = 0; k < 4; k++)
				for (int m = 0; m < 4; m++)
					win_s2[k][m] <= win[k][m];
		end
	end

	// pick the flatter diagonal, fall back to the four-point mean on a tie
	always_comb begin
		pc   = win_s2[1][1];
		ne   = win_s2[1][2];
		sw   = win_s2[2][1];
		se   = win_s2[2][2];
		g1   = abs_diff(pc, se);
		g2   = abs_diff(ne, sw);
		g1t  = {1'b0, g1} + {1'b0, cfg.thresh};
		g2t  = {1'b0, g2} + {1'b0, cfg.thresh};
		sum4 = {2'b00, pc} + {2'b00, ne} + {2'b00, sw} + {2'b00, se} + 10'd2;
		if (g1t < {1'b0, g2})
			centre = half_tap(win_s2[0][0], pc, se, win_s2[3][3]);
		else if (g2t < {1'b0, g1})
			centre = half_tap(win_s2[0][3], ne, sw, win_s2[3][0]);
		else
			centre = sum4[PIX_W+1:2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= req_pop;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			top_left     <= win_s2[1][1];
			top_right    <= half_tap(win_s2[1][0], win_s2[1][1], win_s2[1][2], win_s2[1][3]);
			bottom_left  <= half_tap(win_s2[0][1], win_s2[1][1], win_s2[2][1], win_s2[3][1]);
			bottom_right <= centre;
			block_column <= req_s2.x;
			block_row    <= req_s2.y;
			last_of_run  <= req_s2.last;
			frame_done   <= req_s2.done;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

### rtl/edge_directed_2x_upscaler.sv
// 2x edge-directed grey upscaler: each source pixel in raster order yields one 2x2 output
// block. Pixels are taken one per cycle; blocks leave one per cycle while out_stall is low,
// three after a row's last pixel and up to nine after a frame's; while a burst is issued the
// input is stalled. Order is raster but for the bottom three rows, sent column by column.
// A row's first pixel is held until all blocks of the previous row are read from the four
// line slots. The queue is four deep; from queue to output are three registered stages.
`default_nettype none
module edge_directed_2x_upscaler (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] pixel,
	input  wire logic       start_of_frame,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      top_left,
	output logic [7:0]      top_right,
	output logic [7:0]      bottom_left,
	output logic [7:0]      bottom_right,
	output logic [6:0]      block_column,
	output logic [6:0]      block_row,
	output logic            last_of_run,
	output logic            frame_done
);
	import ed2x_pkg::*;

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [PIX_W-1:0] thresh_q;
	frame_cfg_t       cfg;
	line_wr_t         line_wr;
	logic             q_push;
	logic             q_pop;
	logic             q_full;
	logic             q_empty;
	blk_req_t         q_din;
	blk_req_t         q_dout;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 8'd80;
			height_q <= 8'd60;
			thresh_q <= 8'd4;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ACTIVE_WIDTH:  width_q  <= cfg_data;
				REG_ACTIVE_HEIGHT: height_q <= cfg_data;
				REG_TIE_THRESHOLD: thresh_q <= cfg_data;
				default:           ;
			endcase
		end
	end

	always_comb begin
		cfg.w = (width_q < DIM_MIN) ? DIM_MIN : (width_q > WIDTH_MAX) ? WIDTH_MAX : width_q;
		cfg.h = (height_q < DIM_MIN) ? DIM_MIN :
			(height_q > HEIGHT_MAX) ? HEIGHT_MAX : height_q;
		cfg.thresh = thresh_q;
	end

	ed2x_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.pixel          (pixel),
		.start_of_frame (start_of_frame),
		.line_wr        (line_wr),
		.req_push       (q_push),
		.req            (q_din),
		.req_full       (q_full),
		.req_empty      (q_empty)
	);

	ed2x_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	ed2x_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.line_wr      (line_wr),
		.req_valid    (!q_empty),
		.req          (q_dout),
		.req_pop      (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.top_left     (top_left),
		.top_right    (top_right),
		.bottom_left  (bottom_left),
		.bottom_right (bottom_right),
		.block_column (block_column),
		.block_row    (block_row),
		.last_of_run  (last_of_run),
		.frame_done   (frame_done)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("block queue pushed while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_empty))
		else $error("block queue popped while empty");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_done) |-> last_of_run)
		else $error("frame end block is not last of its run");

endmodule
`default_nettype wire
